// ===== rtl/rnf_pkg.sv =====
// rnf_pkg: shared constants, types and state encoding for the replay nonce filter.
// Used by rnf_scan and replay_nonce_filter; no dependencies.

package rnf_pkg;

  localparam int HISTORY_DEPTH = 32;
  localparam int NONCE_W       = 32;
  localparam int PTR_W         = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int CNT_W         = $clog2(HISTORY_DEPTH + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_WRITE,
    S_DONE
  } state_t;

  // Result handoff from the scan sequencer to the output register.
  typedef struct packed {
    logic valid;
    logic fresh;
  } res_t;

endpackage

// ===== rtl/rnf_ram.sv =====
// rnf_ram: generic single-write, single-read RAM with registered read data.
// Standalone; no package dependencies.

module rnf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/rnf_scan.sv =====
// rnf_scan: sequencer that walks the filled history slots through one RAM read
// port, compares each against the held nonce, then records fresh nonces.
// Depends on rnf_pkg.

module rnf_scan (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [rnf_pkg::NONCE_W-1:0]  start_nonce,
  input  logic                         res_ready,
  input  logic [rnf_pkg::NONCE_W-1:0]  rd_data,
  output logic                         busy,
  output rnf_pkg::res_t                res,
  output logic                         wr_en,
  output logic [rnf_pkg::PTR_W-1:0]    wr_addr,
  output logic [rnf_pkg::NONCE_W-1:0]  wr_data,
  output logic [rnf_pkg::PTR_W-1:0]    rd_addr
);

  rnf_pkg::state_t              state, state_next;
  logic [rnf_pkg::NONCE_W-1:0]  nonce;
  logic [rnf_pkg::CNT_W-1:0]    idx, idx_next;
  logic                         pend, pend_next;
  logic [rnf_pkg::PTR_W-1:0]    wptr;
  logic [rnf_pkg::CNT_W-1:0]    count;
  logic                         fresh, fresh_next;
  logic                         issue;
  logic                         hit;

  assign issue   = (idx < count);
  assign hit     = pend && (rd_data == nonce);
  assign rd_addr = idx[rnf_pkg::PTR_W-1:0];
  assign wr_en   = (state == rnf_pkg::S_WRITE);
  assign wr_addr = wptr;
  assign wr_data = nonce;
  assign busy    = (state != rnf_pkg::S_IDLE);
  assign res.valid = (state == rnf_pkg::S_DONE);
  assign res.fresh = fresh;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rnf_pkg::S_IDLE;
      idx   <= '0;
      pend  <= 1'b0;
      wptr  <= '0;
      count <= '0;
      fresh <= 1'b0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
      pend  <= pend_next;
      fresh <= fresh_next;
      if (state == rnf_pkg::S_WRITE) begin
        if (wptr == rnf_pkg::PTR_W'(rnf_pkg::HISTORY_DEPTH - 1)) begin
          wptr <= '0;
        end else begin
          wptr <= wptr + 1'b1;
        end
        if (count < rnf_pkg::CNT_W'(rnf_pkg::HISTORY_DEPTH)) begin
          count <= count + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && (state == rnf_pkg::S_IDLE)) begin
      nonce <= start_nonce;
    end
  end

  always_comb begin
    state_next = state;
    idx_next   = idx;
    pend_next  = 1'b0;
    fresh_next = fresh;
    case (state)
      rnf_pkg::S_IDLE: begin
        idx_next = '0;
        if (start) begin
          state_next = (count == '0) ? rnf_pkg::S_WRITE : rnf_pkg::S_SCAN;
        end
      end
      rnf_pkg::S_SCAN: begin
        // one read issued and one compare retired per cycle
        if (hit) begin
          fresh_next = 1'b0;
          state_next = rnf_pkg::S_DONE;
        end else if (!issue && !pend) begin
          state_next = rnf_pkg::S_WRITE;
        end else begin
          pend_next = issue;
          if (issue) begin
            idx_next = idx + 1'b1;
          end
        end
      end
      rnf_pkg::S_WRITE: begin
        fresh_next = 1'b1;
        state_next = rnf_pkg::S_DONE;
      end
      rnf_pkg::S_DONE: begin
        // hold until the output register takes the beat
        if (res_ready) begin
          state_next = rnf_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = rnf_pkg::S_IDLE;
      end
    endcase
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= rnf_pkg::CNT_W'(rnf_pkg::HISTORY_DEPTH))
    else $error("filled count beyond history depth");

  a_wptr_range: assert property (@(posedge clk) disable iff (rst)
    int'(wptr) < rnf_pkg::HISTORY_DEPTH)
    else $error("write pointer beyond history depth");

  a_write_fresh: assert property (@(posedge clk) disable iff (rst)
    (state == rnf_pkg::S_WRITE) |=> (state == rnf_pkg::S_DONE) && fresh)
    else $error("write not followed by fresh result");

  a_pend_bound: assert property (@(posedge clk) disable iff (rst)
    pend |-> (idx <= count) && (idx != '0))
    else $error("compare pending with no slot issued");

endmodule

// ===== rtl/replay_nonce_filter.sv =====
// replay_nonce_filter: top level; history RAM, scan sequencer and output register.
// Depends on rnf_pkg, rnf_ram and rnf_scan.
//
//   channel | direction | handshake                  | payload
//   nonce   | in        | nonce_valid / nonce_stall  | nonce[31:0]
//   fresh   | out       | fresh_valid / fresh_stall  | fresh
//
// An item walks all filled slots through the single RAM read port, one slot per
// cycle: a fresh nonce is then written into the ring (with no scan while the ring is empty),
// a replay returns once the matching slot is compared.
// Reset clears pointer, count and control; RAM contents are left as they are.
// A stalled result waits in the output register; the scanner holds its finished
// result until that register frees, and nonce_stall stays high meanwhile.

module replay_nonce_filter (
  input  logic        clk,
  input  logic        rst,
  input  logic        nonce_valid,
  output logic        nonce_stall,
  input  logic [31:0] nonce,
  output logic        fresh_valid,
  input  logic        fresh_stall,
  output logic        fresh
);

  logic                         busy;
  logic                         res_ready;
  rnf_pkg::res_t                res;
  logic                         wr_en;
  logic [rnf_pkg::PTR_W-1:0]    wr_addr;
  logic [rnf_pkg::NONCE_W-1:0]  wr_data;
  logic [rnf_pkg::PTR_W-1:0]    rd_addr;
  logic [rnf_pkg::NONCE_W-1:0]  rd_data;

  assign nonce_stall = busy;
  assign res_ready   = !fresh_valid || !fresh_stall;

  rnf_scan u_scan (
    .clk         (clk),
    .rst         (rst),
    .start       (nonce_valid),
    .start_nonce (nonce),
    .res_ready   (res_ready),
    .rd_data     (rd_data),
    .busy        (busy),
    .res         (res),
    .wr_en       (wr_en),
    .wr_addr     (wr_addr),
    .wr_data     (wr_data),
    .rd_addr     (rd_addr)
  );

  rnf_ram #(
    .WIDTH (rnf_pkg::NONCE_W),
    .DEPTH (rnf_pkg::HISTORY_DEPTH)
  ) u_hist (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  // output register: load a finished result when empty or being drained
  always_ff @(posedge clk) begin
    if (rst) begin
      fresh_valid <= 1'b0;
    end else if (res_ready) begin
      fresh_valid <= res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res.valid) begin
      fresh <= res.fresh;
    end
  end

endmodule
